/* design/slg_pkg.sv */
// Shared types and constants for the spherical Life generation block.
// Used by slg_ctrl, slg_datapath and sphere_life_generation; depends on nothing.
package slg_pkg;

  // Configuration register indexes.
  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  // Configuration register reset value and the smallest usable sizes.
  localparam logic [6:0] CFG_RESET_VALUE = 7'd64;
  localparam logic [6:0] MIN_COLS        = 7'd3;
  localparam logic [6:0] MIN_ROWS        = 7'd2;

  // Neighbor counts of the Life rule.
  localparam int unsigned BIRTH_COUNT = 3;
  localparam int unsigned KEEP_COUNT  = 2;

  // Item commands; code 3 does nothing.
  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_ADVANCE = 2'd2
  } cmd_e;

  // Row memory read address selection.
  typedef enum logic [1:0] {
    RD_ITEM,
    RD_LAST,
    RD_FIRST,
    RD_NEXT
  } rd_sel_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ACCESS,
    ST_POLE_A,
    ST_POLE_B,
    ST_POLE_C,
    ST_SWEEP,
    ST_RESP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    item_ld;
    logic    res_clr;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    cell_wr;
    logic    cell_rd;
    logic    cnt_en;
    logic    bot_ld;
    logic    top_ld;
    logic    shift;
    logic    sweep_clr;
    logic    sweep_wr;
    logic    out_ld;
  } slg_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_e cmd;
    logic oor;
    logic last_row;
  } slg_sts_t;

endpackage

/* design/slg_ctrl.sv */
// Controller state machine for the spherical Life block.
// Depends on slg_pkg for the state type and the command and status structs.
module slg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  slg_pkg::slg_sts_t sts_i,
  output slg_pkg::slg_ctl_t ctl_o
);

  slg_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  // The output register can take a result when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  // State and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slg_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      slg_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = slg_pkg::ST_DISPATCH;
      end
      slg_pkg::ST_DISPATCH: begin
        unique case (sts_i.cmd) inside
          slg_pkg::CMD_WRITE, slg_pkg::CMD_READ: begin
            state_d = sts_i.oor ? slg_pkg::ST_RESP : slg_pkg::ST_ACCESS;
          end
          slg_pkg::CMD_ADVANCE: state_d = slg_pkg::ST_POLE_A;
          default:              state_d = slg_pkg::ST_RESP;
        endcase
      end
      slg_pkg::ST_ACCESS: state_d = slg_pkg::ST_RESP;
      slg_pkg::ST_POLE_A: state_d = slg_pkg::ST_POLE_B;
      slg_pkg::ST_POLE_B: state_d = slg_pkg::ST_POLE_C;
      slg_pkg::ST_POLE_C: state_d = slg_pkg::ST_SWEEP;
      slg_pkg::ST_SWEEP: begin
        if (sts_i.last_row) state_d = slg_pkg::ST_RESP;
      end
      slg_pkg::ST_RESP: begin
        if (out_free) state_d = slg_pkg::ST_IDLE;
      end
      default: state_d = slg_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands for each state.
  always_comb begin
    ctl_o = '0;
    ctl_o.rd_sel = slg_pkg::RD_ITEM;
    unique case (state_q)
      slg_pkg::ST_IDLE: begin
        ctl_o.item_ld = in_valid_i;
      end
      slg_pkg::ST_DISPATCH: begin
        ctl_o.res_clr = 1'b1;
        unique case (sts_i.cmd) inside
          slg_pkg::CMD_WRITE, slg_pkg::CMD_READ: begin
            ctl_o.rd_en  = !sts_i.oor;
            ctl_o.rd_sel = slg_pkg::RD_ITEM;
          end
          slg_pkg::CMD_ADVANCE: begin
            ctl_o.rd_en  = 1'b1;
            ctl_o.rd_sel = slg_pkg::RD_LAST;
          end
          default: ;
        endcase
      end
      slg_pkg::ST_ACCESS: begin
        ctl_o.cell_wr = (sts_i.cmd == slg_pkg::CMD_WRITE);
        ctl_o.cell_rd = (sts_i.cmd == slg_pkg::CMD_READ);
      end
      slg_pkg::ST_POLE_A: begin
        ctl_o.rd_en  = 1'b1;
        ctl_o.rd_sel = slg_pkg::RD_FIRST;
        ctl_o.cnt_en = 1'b1;
      end
      slg_pkg::ST_POLE_B: begin
        ctl_o.rd_en  = 1'b1;
        ctl_o.rd_sel = slg_pkg::RD_NEXT;
        ctl_o.cnt_en = 1'b1;
        ctl_o.bot_ld = 1'b1;
        ctl_o.shift  = 1'b1;
      end
      slg_pkg::ST_POLE_C: begin
        ctl_o.rd_en     = 1'b1;
        ctl_o.rd_sel    = slg_pkg::RD_NEXT;
        ctl_o.top_ld    = 1'b1;
        ctl_o.shift     = 1'b1;
        ctl_o.sweep_clr = 1'b1;
      end
      slg_pkg::ST_SWEEP: begin
        ctl_o.rd_en    = 1'b1;
        ctl_o.rd_sel   = slg_pkg::RD_NEXT;
        ctl_o.sweep_wr = 1'b1;
        ctl_o.shift    = 1'b1;
      end
      slg_pkg::ST_RESP: begin
        ctl_o.out_ld = out_free;
      end
      default: ;
    endcase
  end

  // A result stays valid until its transaction completes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_ready_o  = (state_q == slg_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* design/slg_datapath.sv */
// Datapath of the spherical Life block: configuration, row memory, three-row
// window, pole counters and next-generation logic. Depends on slg_pkg.
module slg_datapath #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_index_i,
  input  logic [6:0]        cfg_data_i,
  input  logic [1:0]        command_i,
  input  logic [5:0]        row_i,
  input  logic [5:0]        column_i,
  input  logic              cell_in_i,
  input  slg_pkg::slg_ctl_t ctl_i,
  output slg_pkg::slg_sts_t sts_o,
  output logic              cell_out_o,
  output logic              out_of_range_o
);

  localparam int unsigned RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CLW = $clog2(MAX_COLS);
  localparam int unsigned PSW = $clog2(MAX_COLS + 1);
  localparam int unsigned NG  = (MAX_COLS + 7) / 8;
  localparam int unsigned NW  = (PSW + 1 > 4) ? PSW + 1 : 4;

  // Configuration registers and the sizes in use.
  logic [6:0]     width_q, height_q;
  logic [6:0]     used_w, used_h;
  logic [RW-1:0]  last_row;
  logic [CLW-1:0] col_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= slg_pkg::CFG_RESET_VALUE;
      height_q <= slg_pkg::CFG_RESET_VALUE;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        slg_pkg::CFG_GRID_WIDTH:  width_q  <= cfg_data_i;
        slg_pkg::CFG_GRID_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < slg_pkg::MIN_COLS) begin
      used_w = slg_pkg::MIN_COLS;
    end else if (width_q > 7'(MAX_COLS)) begin
      used_w = 7'(MAX_COLS);
    end else begin
      used_w = width_q;
    end
    if (height_q < slg_pkg::MIN_ROWS) begin
      used_h = slg_pkg::MIN_ROWS;
    end else if (height_q > 7'(MAX_ROWS)) begin
      used_h = 7'(MAX_ROWS);
    end else begin
      used_h = height_q;
    end
  end

  assign last_row = RW'(used_h - 7'd1);
  assign col_last = CLW'(used_w - 7'd1);

  // Item registers, loaded when the input transaction completes.
  slg_pkg::cmd_e  cmd_q;
  logic [5:0]     row_q, col_q;
  logic           cell_q;
  logic [RW-1:0]  item_row;
  logic [CLW-1:0] item_col;
  logic           oor;

  always_ff @(posedge clk_i) begin
    if (ctl_i.item_ld) begin
      cmd_q  <= slg_pkg::cmd_e'(command_i);
      row_q  <= row_i;
      col_q  <= column_i;
      cell_q <= cell_in_i;
    end
  end

  assign item_row = RW'({1'b0, row_q});
  assign item_col = CLW'({1'b0, col_q});
  assign oor = ((cmd_q == slg_pkg::CMD_WRITE) || (cmd_q == slg_pkg::CMD_READ)) &&
               (({1'b0, row_q} >= used_h) || ({1'b0, col_q} >= used_w));

  // Row memory with a valid bit per row; a row never written reads as dead.
  logic [MAX_COLS-1:0] mem_q [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_vld_q;
  logic [MAX_COLS-1:0] rd_data_q, rd_row;
  logic                rd_vld_q;
  logic [RW-1:0]       rd_addr, rd_row_q, rd_next;
  logic                wr_en;
  logic [RW-1:0]       wr_addr;
  logic [MAX_COLS-1:0] wr_data, cell_row, new_row;
  logic [RW-1:0]       sweep_q;

  // Read address: the item row, a pole row, or the next row of the sweep.
  assign rd_next = (rd_row_q == last_row) ? last_row : rd_row_q + 1'b1;

  always_comb begin
    unique case (ctl_i.rd_sel)
      slg_pkg::RD_ITEM:  rd_addr = item_row;
      slg_pkg::RD_LAST:  rd_addr = last_row;
      slg_pkg::RD_FIRST: rd_addr = '0;
      slg_pkg::RD_NEXT:  rd_addr = rd_next;
      default:           rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_vld_q  <= row_vld_q[rd_addr];
      rd_row_q  <= rd_addr;
    end
  end

  assign rd_row = rd_vld_q ? rd_data_q : '0;

  // Write port: a single cell by read-modify-write, or a whole swept row.
  always_comb begin
    cell_row           = rd_row;
    cell_row[item_col] = cell_q;
  end

  assign wr_en   = ctl_i.cell_wr || ctl_i.sweep_wr;
  assign wr_addr = ctl_i.sweep_wr ? sweep_q : item_row;
  assign wr_data = ctl_i.sweep_wr ? new_row : cell_row;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (wr_en) begin
      row_vld_q[wr_addr] <= 1'b1;
    end
  end

  // Three-row window of old rows: previous, current and next.
  logic [MAX_COLS-1:0] prev_q, cur_q, nxt_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      prev_q <= cur_q;
      cur_q  <= nxt_q;
      nxt_q  <= rd_row;
    end
  end

  // Sweep row counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (ctl_i.sweep_clr) begin
      sweep_q <= '0;
    end else if (ctl_i.sweep_wr) begin
      sweep_q <= sweep_q + 1'b1;
    end
  end

  // Pole population count: byte counts in one cycle, their sum in the next.
  logic [MAX_COLS-1:0] col_mask;
  logic [3:0]          grp_d [NG];
  logic [3:0]          grp_q [NG];
  logic [PSW-1:0]      pole_sum;
  logic [PSW-1:0]      top_sum_q, bot_sum_q;

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = (7'(c) < used_w);
    end
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_d[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (8 * g + b < MAX_COLS) begin
          grp_d[g] = grp_d[g] + 4'(rd_row[8 * g + b] & col_mask[8 * g + b]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cnt_en) begin
      grp_q <= grp_d;
    end
  end

  always_comb begin
    pole_sum = '0;
    for (int g = 0; g < NG; g++) begin
      pole_sum = pole_sum + PSW'(grp_q[g]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_sum_q <= '0;
      bot_sum_q <= '0;
    end else begin
      if (ctl_i.bot_ld) bot_sum_q <= pole_sum;
      if (ctl_i.top_ld) top_sum_q <= pole_sum;
    end
  end

  // Wrapped left and right neighbors of each column in the window rows.
  logic                prev_wrap, cur_wrap, nxt_wrap;
  logic [MAX_COLS-1:0] pl, pr, cl, cr, nl, nr;

  assign prev_wrap = prev_q[col_last];
  assign cur_wrap  = cur_q[col_last];
  assign nxt_wrap  = nxt_q[col_last];

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      if (c == 0) begin
        pl[c] = prev_wrap;
        cl[c] = cur_wrap;
        nl[c] = nxt_wrap;
      end else begin
        pl[c] = prev_q[c - 1];
        cl[c] = cur_q[c - 1];
        nl[c] = nxt_q[c - 1];
      end
      if (c == MAX_COLS - 1) begin
        pr[c] = prev_q[0];
        cr[c] = cur_q[0];
        nr[c] = nxt_q[0];
      end else if (CLW'(c) == col_last) begin
        pr[c] = prev_q[0];
        cr[c] = cur_q[0];
        nr[c] = nxt_q[0];
      end else begin
        pr[c] = prev_q[c + 1];
        cr[c] = cur_q[c + 1];
        nr[c] = nxt_q[c + 1];
      end
    end
  end

  // Neighbor counts and the Life rule for the current row.
  logic          is_top, is_bot;
  logic [NW-1:0] three_p [MAX_COLS];
  logic [NW-1:0] three_n [MAX_COLS];
  logic [NW-1:0] ncount  [MAX_COLS];

  assign is_top = (sweep_q == '0);
  assign is_bot = !is_top && (sweep_q == last_row);

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      three_p[c] = NW'(pl[c]) + NW'(prev_q[c]) + NW'(pr[c]);
      three_n[c] = NW'(nl[c]) + NW'(nxt_q[c]) + NW'(nr[c]);
      if (is_top) begin
        ncount[c] = NW'(top_sum_q) - NW'(cur_q[c]) + three_n[c];
      end else if (is_bot) begin
        ncount[c] = NW'(bot_sum_q) - NW'(cur_q[c]) + three_p[c];
      end else begin
        ncount[c] = three_p[c] + NW'(cl[c]) + NW'(cr[c]) + three_n[c];
      end
      if (col_mask[c]) begin
        new_row[c] = (ncount[c] == NW'(slg_pkg::BIRTH_COUNT)) ||
                     ((ncount[c] == NW'(slg_pkg::KEEP_COUNT)) && cur_q[c]);
      end else begin
        new_row[c] = cur_q[c];
      end
    end
  end

  // Result of a read, then the output payload register.
  logic res_cell_q, cell_out_q, oor_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.res_clr) begin
      res_cell_q <= 1'b0;
    end else if (ctl_i.cell_rd) begin
      res_cell_q <= rd_row[item_col];
    end
    if (ctl_i.out_ld) begin
      cell_out_q <= res_cell_q;
      oor_q      <= oor;
    end
  end

  assign cell_out_o     = cell_out_q;
  assign out_of_range_o = oor_q;

  assign sts_o.cmd      = cmd_q;
  assign sts_o.oor      = oor;
  assign sts_o.last_row = (sweep_q == last_row);

endmodule

/* design/sphere_life_generation.sv */
// Top level of the spherical Life block; instantiates slg_ctrl and slg_datapath.
// A new item is accepted only once the result of the last one is in the output
// register. Write and read go through dispatch, access and response; advance
// goes through dispatch, the pole count states A, B and C, and a sweep of the h
// rows in use, one memory row read and one row write per cycle, then response.
// Out-of-range accesses and unused commands go from dispatch to response. Reset
// clears all cells at once via per-row valid bits; both size registers go to 64.
module sphere_life_generation #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [6:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  input  logic [5:0] row_i,
  input  logic [5:0] column_i,
  input  logic       cell_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       cell_out_o,
  output logic       out_of_range_o
);

  slg_pkg::slg_ctl_t ctl;
  slg_pkg::slg_sts_t sts;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Sequencing of commands.
  slg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // Grid storage and generation logic.
  slg_datapath #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .command_i     (command_i),
    .row_i         (row_i),
    .column_i      (column_i),
    .cell_in_i     (cell_in_i),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .cell_out_o    (cell_out_o),
    .out_of_range_o(out_of_range_o)
  );

endmodule
